### rtl/ffc_pkg.sv
// Shared types and constants for the float format converter.
package ffc_pkg;

  localparam logic [1:0] CMD_H2S  = 2'd0;
  localparam logic [1:0] CMD_S2H  = 2'd1;
  localparam logic [1:0] CMD_BF2H = 2'd2;

  localparam logic [7:0]  HALF_BIAS_ADJ = 8'd112;
  localparam logic [7:0]  HSUB_EXP_BASE = 8'd113;
  localparam logic [7:0]  S2H_SUB_BASE  = 8'd126;
  localparam logic [7:0]  S2H_TINY_EXP  = 8'd102;
  localparam logic [7:0]  S2H_OVF_EXP   = 8'd143;
  localparam logic [7:0]  EXP_ALL_ONES  = 8'hff;
  localparam logic [4:0]  HALF_EXP_MAX  = 5'h1f;
  localparam logic [23:0] S2H_RND_INC   = 24'h001000;

  localparam logic [31:0] SGL_INF   = 32'h7f800000;
  localparam logic [31:0] SGL_QNAN  = 32'h7fffc000;
  localparam logic [15:0] HALF_INF  = 16'h7c00;
  localparam logic [15:0] HALF_QNAN = 16'h7e00;

  typedef enum logic [2:0] {
    CAT_NONE,
    CAT_ZERO,
    CAT_INF,
    CAT_NAN,
    CAT_NORM,
    CAT_H_SUB,
    CAT_S_SUB,
    CAT_S_NORM
  } cat_t;

  typedef struct packed {
    cat_t        cat;
    logic        sign;
    logic        half_out;
    logic [7:0]  exp;
    logic [22:0] mant;
    logic [4:0]  shamt;
  } dec_t;

  typedef struct packed {
    cat_t        cat;
    logic        sign;
    logic        half_out;
    logic [7:0]  exp;
    logic [22:0] mant;
  } val_t;

  // shifts needed to bring the msb of a nonzero half subnormal fraction to bit 10
  function automatic logic [4:0] hsub_shift(input logic [9:0] m);
    logic [4:0] sh;
    sh = 5'd10;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) sh = 5'(10 - i);
    end
    return sh;
  endfunction

endpackage

### rtl/ffc_round.sv
// Second pipeline stage: subnormal alignment, rounding and exponent carry.
module ffc_round
  import ffc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic vld_in,
  input  dec_t dec_in,
  output logic vld_out,
  output val_t val_out
);

  logic        vld_r;
  val_t        val_r;
  val_t        val_nxt;
  logic [10:0] hsub_mm;
  logic [23:0] ssub_a;
  logic [23:0] ssub_sh;
  logic [11:0] ssub_q1;
  logic [10:0] ssub_v;
  logic [23:0] snorm_sum;
  logic [7:0]  snorm_exp;

  always_comb begin
    hsub_mm   = {1'b0, dec_in.mant[22:13]} << dec_in.shamt;
    ssub_a    = {1'b1, dec_in.mant};
    ssub_sh   = ssub_a >> 5'(dec_in.shamt - 5'd1);
    ssub_q1   = {1'b0, ssub_sh[10:0]} + 12'd1;
    ssub_v    = ssub_q1[11:1];
    snorm_sum = {1'b0, dec_in.mant} + S2H_RND_INC;
    snorm_exp = dec_in.exp + {7'd0, snorm_sum[23]};

    val_nxt.cat      = dec_in.cat;
    val_nxt.sign     = dec_in.sign;
    val_nxt.half_out = dec_in.half_out;
    val_nxt.exp      = dec_in.exp;
    val_nxt.mant     = dec_in.mant;
    unique case (dec_in.cat)
      CAT_H_SUB: begin
        val_nxt.cat  = CAT_NORM;
        val_nxt.exp  = HSUB_EXP_BASE - {3'd0, dec_in.shamt};
        val_nxt.mant = {hsub_mm[9:0], 13'd0};
      end
      CAT_S_SUB: begin
        val_nxt.cat  = CAT_NORM;
        val_nxt.exp  = {7'd0, ssub_v[10]};
        val_nxt.mant = {ssub_v[9:0], 13'd0};
      end
      CAT_S_NORM: begin
        val_nxt.exp  = snorm_exp;
        val_nxt.mant = snorm_sum[23] ? 23'd0 : snorm_sum[22:0];
        val_nxt.cat  = (snorm_exp[4:0] == HALF_EXP_MAX) ? CAT_INF : CAT_NORM;
      end
      CAT_NONE, CAT_ZERO, CAT_INF, CAT_NAN, CAT_NORM: begin
        val_nxt.cat = dec_in.cat;
      end
      default: val_nxt.cat = CAT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign vld_out = vld_r;
  assign val_out = val_r;

endmodule

### rtl/float_format_converter_core.sv
// Top level of the float format converter: decode, round and pack stages.
//
// Usage:
//   Command channel: drive in_cmd and in_source_bits with start high; the
//   transfer happens at the rising edge where start is high and busy is low.
//   in_cmd 0 converts half to single, 1 single to half, 2 bfloat16 to half,
//   3 returns zero. 16-bit sources use bits 15..0 of in_source_bits.
//   Result channel: out_valid strobes for one cycle with out_result_bits;
//   half results sit in bits 15..0 with the upper half zero.
//   Pipeline: a command passes the decode register, the round register and
//   the output register before its result is presented.
//   Throughput: one item per cycle; busy is low whenever reset is released,
//   so a new command may be given every cycle.
//   Reset: synchronous, active low; busy is high during reset and all
//   in-flight items are dropped.
//   The receiver cannot stall: results are presented exactly once.
module float_format_converter_core
  import ffc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_source_bits,
  output logic        out_valid,
  output logic [31:0] out_result_bits
);

  logic        acc;
  dec_t        dec_nxt;
  dec_t        dec_r;
  logic        dec_vld_r;
  logic        val_vld;
  val_t        val;
  logic        out_valid_r;
  logic [31:0] out_bits_r;
  logic [31:0] out_bits_nxt;
  logic [7:0]  be;
  logic [7:0]  bfe;

  assign busy = ~rst_n;
  assign acc  = start & ~busy;

  // stage 1: classify
  always_comb begin
    be  = in_source_bits[30:23];
    bfe = in_source_bits[14:7];
    dec_nxt.cat      = CAT_NONE;
    dec_nxt.sign     = 1'b0;
    dec_nxt.half_out = 1'b1;
    dec_nxt.exp      = 8'd0;
    dec_nxt.mant     = 23'd0;
    dec_nxt.shamt    = 5'd0;
    unique case (in_cmd)
      CMD_H2S: begin
        dec_nxt.sign     = in_source_bits[15];
        dec_nxt.half_out = 1'b0;
        dec_nxt.mant     = {in_source_bits[9:0], 13'd0};
        dec_nxt.exp      = {3'd0, in_source_bits[14:10]} + HALF_BIAS_ADJ;
        dec_nxt.shamt    = hsub_shift(in_source_bits[9:0]);
        priority if (in_source_bits[14:10] == 5'd0) begin
          dec_nxt.cat = (in_source_bits[9:0] == 10'd0) ? CAT_ZERO : CAT_H_SUB;
        end else if (in_source_bits[14:10] == HALF_EXP_MAX) begin
          dec_nxt.cat = (in_source_bits[9:0] != 10'd0) ? CAT_NAN : CAT_INF;
        end else begin
          dec_nxt.cat = CAT_NORM;
        end
      end
      CMD_S2H: begin
        dec_nxt.sign  = in_source_bits[31];
        dec_nxt.mant  = in_source_bits[22:0];
        dec_nxt.exp   = be - HALF_BIAS_ADJ;
        dec_nxt.shamt = 5'(S2H_SUB_BASE - be);
        priority if (be == 8'd0) begin
          dec_nxt.cat = CAT_ZERO;
        end else if (be == EXP_ALL_ONES) begin
          dec_nxt.cat = (in_source_bits[22:0] != 23'd0) ? CAT_NAN : CAT_INF;
        end else if (be >= S2H_OVF_EXP) begin
          dec_nxt.cat = CAT_INF;
        end else if (be < S2H_TINY_EXP) begin
          dec_nxt.cat = CAT_ZERO;
        end else if (be <= HALF_BIAS_ADJ) begin
          dec_nxt.cat = CAT_S_SUB;
        end else begin
          dec_nxt.cat = CAT_S_NORM;
        end
      end
      CMD_BF2H: begin
        dec_nxt.sign = in_source_bits[15];
        dec_nxt.mant = {in_source_bits[6:0], 16'd0};
        dec_nxt.exp  = bfe - HALF_BIAS_ADJ;
        priority if (bfe == EXP_ALL_ONES) begin
          dec_nxt.cat = (in_source_bits[6:0] != 7'd0) ? CAT_NAN : CAT_INF;
        end else if (bfe <= HALF_BIAS_ADJ) begin
          dec_nxt.cat = CAT_ZERO;
        end else if (bfe >= S2H_OVF_EXP) begin
          dec_nxt.cat = CAT_INF;
        end else begin
          dec_nxt.cat = CAT_NORM;
        end
      end
      default: dec_nxt.cat = CAT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_vld_r <= 1'b0;
    end else begin
      dec_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
  end

  // stage 2
  ffc_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (dec_vld_r),
    .dec_in  (dec_r),
    .vld_out (val_vld),
    .val_out (val)
  );

  // stage 3: pack
  always_comb begin
    out_bits_nxt = 32'd0;
    unique case (val.cat)
      CAT_NONE: out_bits_nxt = 32'd0;
      CAT_ZERO: out_bits_nxt = val.half_out ? {16'd0, val.sign, 15'd0}
                                            : {val.sign, 31'd0};
      CAT_INF:  out_bits_nxt = val.half_out ? {16'd0, val.sign, HALF_INF[14:0]}
                                            : {val.sign, SGL_INF[30:0]};
      CAT_NAN:  out_bits_nxt = val.half_out ? {16'd0, val.sign, HALF_QNAN[14:0]}
                                            : {val.sign, SGL_QNAN[30:0]};
      CAT_NORM, CAT_H_SUB, CAT_S_SUB, CAT_S_NORM: begin
        out_bits_nxt = val.half_out
                     ? {16'd0, val.sign, val.exp[4:0], val.mant[22:13]}
                     : {val.sign, val.exp, val.mant};
      end
      default: out_bits_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= val_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_bits_r <= out_bits_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_bits_r;

endmodule

### sim/tb_top.sv
// Self-checking testbench for float_format_converter_core: half, single and bfloat16 conversions.
`timescale 1ns / 1ps

module tb_top;
  import ffc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 825;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIRECTED = 25;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] src;
    logic [31:0] bits;
  } pending_t;

  class conversion_tracker;
    pending_t pending_results[$];
    int mismatches;
    int results_seen;
    int count_by_cmd[4];

    function logic [31:0] widen_half(logic [15:0] h);
      logic [9:0] m;
      logic [4:0] e;
      logic [10:0] norm;
      int unsigned sh;
      m = h[9:0];
      e = h[14:10];
      if (e == 5'd0) begin
        if (m == 10'd0) return {h[15], 31'd0};
        norm = {1'b0, m};
        sh = 0;
        while (!norm[10]) begin
          norm = norm << 1;
          sh++;
        end
        return {h[15], 8'(int'(HSUB_EXP_BASE) - int'(sh)), norm[9:0], 13'd0};
      end
      if (e == HALF_EXP_MAX) return (m != 10'd0) ? {h[15], SGL_QNAN[30:0]} : {h[15], SGL_INF[30:0]};
      return {h[15], 8'(e + HALF_BIAS_ADJ), m, 13'd0};
    endfunction

    function logic [31:0] narrow_single(logic [31:0] x);
      logic sgn;
      logic [7:0] be;
      logic [22:0] frac;
      logic [31:0] mag;
      int ex;
      int shift;
      sgn = x[31];
      be = x[30:23];
      frac = x[22:0];
      ex = int'(be) - int'(HALF_BIAS_ADJ);
      if (be == 8'd0) return {16'd0, sgn, 15'd0};
      if (be == EXP_ALL_ONES)
        return {16'd0, sgn, (frac != 23'd0) ? HALF_QNAN[14:0] : HALF_INF[14:0]};
      if (ex >= 31) return {16'd0, sgn, HALF_INF[14:0]};
      if (ex <= 0) begin
        if (ex < -10) return {16'd0, sgn, 15'd0};
        mag = {8'd0, 1'b1, frac};
        shift = 14 - ex;
        mag = (mag + (32'd1 << (shift - 1))) >> shift;
        return {16'd0, sgn, mag[14:0]};
      end
      mag = {9'd0, frac} + S2H_RND_INC;
      if (mag[23]) begin
        mag = 32'd0;
        ex++;
        if (ex >= 31) return {16'd0, sgn, HALF_INF[14:0]};
      end
      return {16'd0, sgn, 5'(ex), mag[22:13]};
    endfunction

    function logic [31:0] narrow_bfloat(logic [15:0] b);
      logic [7:0] e;
      logic [6:0] m;
      int ne;
      e = b[14:7];
      m = b[6:0];
      ne = int'(e) - int'(HALF_BIAS_ADJ);
      if (e == EXP_ALL_ONES)
        return {16'd0, b[15], (m != 7'd0) ? HALF_QNAN[14:0] : HALF_INF[14:0]};
      if (ne <= 0) return {16'd0, b[15], 15'd0};
      if (ne >= 31) return {16'd0, b[15], HALF_INF[14:0]};
      return {16'd0, b[15], 5'(ne), m, 3'd0};
    endfunction

    function logic [31:0] predict_conversion(logic [1:0] cmd, logic [31:0] src);
      case (cmd)
        CMD_H2S:  return widen_half(src[15:0]);
        CMD_S2H:  return narrow_single(src);
        CMD_BF2H: return narrow_bfloat(src[15:0]);
        default:  return 32'd0;
      endcase
    endfunction

    function void note_command(logic [1:0] cmd, logic [31:0] src);
      pending_t p;
      p.cmd = cmd;
      p.src = src;
      p.bits = predict_conversion(cmd, src);
      pending_results.push_back(p);
      count_by_cmd[cmd]++;
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [31:0] got);
      pending_t p;
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result %h with no transfer pending", got));
      end else begin
        p = pending_results.pop_front();
        if (got !== p.bits)
          flag_mismatch($sformatf("cmd %0d src %h: result_bits %h, predicted %h",
                                  p.cmd, p.src, got, p.bits));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = CMD_H2S;
  logic [31:0] in_source_bits = 32'd0;
  logic        out_valid;
  logic [31:0] out_result_bits;
  int          cycle_count = 0;

  conversion_tracker tracker = new();

  float_format_converter_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_source_bits (in_source_bits),
    .out_valid      (out_valid),
    .out_result_bits(out_result_bits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (start === 1'b1 && busy === 1'b0) tracker.note_command(in_cmd, in_source_bits);
      if (out_valid === 1'b1) tracker.check_result(out_result_bits);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task send_command(input logic [1:0] cmd, input logic [31:0] src);
    in_cmd <= cmd;
    in_source_bits <= src;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [1:0] pick_command();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return CMD_UNUSED;
    case (r % 3)
      0:       return CMD_H2S;
      1:       return CMD_S2H;
      default: return CMD_BF2H;
    endcase
  endfunction

  function automatic logic [31:0] make_source(logic [1:0] cmd);
    logic [31:0] raw;
    logic [7:0] ex8;
    logic [4:0] ex5;
    raw = $urandom;
    if ($urandom_range(0, 3) == 0) return raw;
    case (cmd)
      CMD_H2S: begin
        case ($urandom_range(0, 3))
          0:       ex5 = 5'd0;
          1:       ex5 = HALF_EXP_MAX;
          2:       ex5 = 5'($urandom_range(1, 2));
          default: ex5 = 5'($urandom);
        endcase
        raw[14:10] = ex5;
      end
      CMD_S2H: begin
        case ($urandom_range(0, 5))
          0:       ex8 = 8'd0;
          1:       ex8 = EXP_ALL_ONES;
          2:       ex8 = 8'($urandom_range(100, 114));
          3:       ex8 = 8'($urandom_range(140, 144));
          default: ex8 = 8'($urandom_range(95, 150));
        endcase
        raw[30:23] = ex8;
        case ($urandom_range(0, 3))
          0:       raw[12:0] = 13'h1000;
          1:       raw[12:0] = 13'h0fff;
          2:       raw[22:13] = '1;
          default: ;
        endcase
      end
      CMD_BF2H: begin
        case ($urandom_range(0, 4))
          0:       ex8 = 8'd0;
          1:       ex8 = EXP_ALL_ONES;
          2:       ex8 = 8'($urandom_range(108, 116));
          3:       ex8 = 8'($urandom_range(139, 145));
          default: ex8 = 8'($urandom);
        endcase
        raw[14:7] = ex8;
      end
      default: ;
    endcase
    return raw;
  endfunction

  logic [1:0] dir_cmd [N_DIRECTED] = '{
    CMD_H2S, CMD_H2S, CMD_H2S, CMD_H2S, CMD_H2S, CMD_H2S, CMD_H2S, CMD_H2S, CMD_H2S,
    CMD_S2H, CMD_S2H, CMD_S2H, CMD_S2H, CMD_S2H, CMD_S2H, CMD_S2H, CMD_S2H, CMD_S2H,
    CMD_S2H, CMD_S2H,
    CMD_BF2H, CMD_BF2H, CMD_BF2H, CMD_BF2H,
    CMD_UNUSED
  };
  logic [31:0] dir_src [N_DIRECTED] = '{
    32'h00000000, 32'hffff8000, 32'h00000001, 32'h000003ff, 32'h00008200,
    32'h00000400, 32'h00007bff, 32'h0000fc00, 32'habcd7e01,
    32'h00000000, 32'h80000001, 32'h33000000, 32'h32ffffff, 32'h387fffff,
    32'h3ffff000, 32'h477fe000, 32'h477ff000, 32'hff800000, 32'h7fc00001,
    32'h3f801000,
    32'hffff0001, 32'h00003880, 32'h00004780, 32'h0000ff81,
    32'hffffffff
  };

  initial begin
    int sent;
    int burst;
    bit drained;
    logic [1:0] cmd;
    sent = 0;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) send_command(dir_cmd[i], dir_src[i]);
    drain_pipeline();

    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        cmd = pick_command();
        send_command(cmd, make_source(cmd));
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        drain_pipeline();
        drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 8));
      end
    end

    drain_pipeline();
    repeat (6) @(posedge clk);
    if (tracker.pending_results.size() != 0)
      tracker.flag_mismatch($sformatf("%0d results never arrived",
                                      tracker.pending_results.size()));
    $display("transfers: half->single %0d, single->half %0d, bf16->half %0d, unused cmd %0d",
             tracker.count_by_cmd[CMD_H2S], tracker.count_by_cmd[CMD_S2H],
             tracker.count_by_cmd[CMD_BF2H], tracker.count_by_cmd[CMD_UNUSED]);
    $display("results checked %0d, mismatches %0d", tracker.results_seen,
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
